@@ design/rotate_vector_by_quaternion_defines.svh @@
// Assertion helpers used by the checker file.
`ifndef ROTATE_VECTOR_BY_QUATERNION_DEFINES_SVH
`define ROTATE_VECTOR_BY_QUATERNION_DEFINES_SVH

// Concurrent check, masked while reset is high.
`define RVQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define RVQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/rvq_pkg.sv @@
package rvq_pkg;

  localparam int VEC_W  = 24;
  localparam int QUAT_W = 16;
  localparam int PUV_W  = VEC_W + QUAT_W;      // u*v product
  localparam int PSQ_W  = 2 * QUAT_W;          // u*u product
  localparam int UV_W   = PUV_W + 2;           // sum of three u*v
  localparam int S2_W   = PSQ_W + 2;           // w*w - u.u
  localparam int CR_W   = PUV_W + 1;           // cross product term
  localparam int T1_W   = UV_W + QUAT_W;
  localparam int T2_W   = S2_W + VEC_W;
  localparam int T3_W   = CR_W + QUAT_W;
  localparam int ACC_W  = 60;
  localparam int SHIFT_OUT = 28;
  localparam int RND_W  = ACC_W - SHIFT_OUT;

  localparam int OUT_MAX = 8388607;
  localparam int OUT_MIN = -8388608;

  typedef struct packed {
    logic ce;
    logic valid;
  } stage_ctrl_t;

endpackage

@@ design/rotate_vector_by_quaternion.sv @@
// Quaternion rotation of a fixed-point 3-vector.
// Input stream (s_*): one transfer carries the vector (Q7.16) and the
// quaternion (Q1.14); the quaternion is not normalized, so |q|^2 also
// scales the result. Output stream (m_*): the rotated vector, rounded to
// nearest (ties up) and saturated to 24 bits; m_tuser flags saturation.
// Throughput: one transfer per cycle while the output is not stalled. The
// datapath has five register stages (products, sums, term multiplies, wide
// add, round and clamp); m_tvalid is registered along with the last stage.
// Stall: while m_tvalid is high and m_tready low the whole pipeline holds
// and s_tready drops; bubbles are not squeezed out during a stall.
// s_tready is high whenever the output register is empty or being taken.
// Reset (rst, synchronous): clears all valid bits; no result is in flight
// afterwards. There is no state carried between items.
module rotate_vector_by_quaternion (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z
  input  logic [135:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // rot_x, rot_y, rot_z
  output logic [71:0]  m_tdata,
  // saturated
  output logic         m_tuser
);

  rvq_pkg::stage_ctrl_t                  ctrl;
  logic signed [rvq_pkg::VEC_W-1:0]      vec [3];
  logic signed [rvq_pkg::QUAT_W-1:0]     quat_w;
  logic signed [rvq_pkg::QUAT_W-1:0]     quat_u [3];
  logic signed [rvq_pkg::VEC_W-1:0]      rot [3];

  assign ctrl.ce    = !m_tvalid || m_tready;
  assign ctrl.valid = s_tvalid;
  assign s_tready   = ctrl.ce;

  assign vec[0]    = s_tdata[23:0];
  assign vec[1]    = s_tdata[47:24];
  assign vec[2]    = s_tdata[71:48];
  assign quat_w    = s_tdata[87:72];
  assign quat_u[0] = s_tdata[103:88];
  assign quat_u[1] = s_tdata[119:104];
  assign quat_u[2] = s_tdata[135:120];

  rvq_core u_core (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .vec       (vec),
    .quat_w    (quat_w),
    .quat_u    (quat_u),
    .rot       (rot),
    .saturated (m_tuser),
    .out_valid (m_tvalid)
  );

  assign m_tdata = {rot[2], rot[1], rot[0]};

endmodule

@@ design/rvq_core.sv @@
module rvq_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rvq_pkg::stage_ctrl_t                  ctrl,
  input  logic signed [rvq_pkg::VEC_W-1:0]      vec [3],
  input  logic signed [rvq_pkg::QUAT_W-1:0]     quat_w,
  input  logic signed [rvq_pkg::QUAT_W-1:0]     quat_u [3],
  output logic signed [rvq_pkg::VEC_W-1:0]      rot [3],
  output logic                                  saturated,
  output logic                                  out_valid
);

  logic [3:0] valid;

  // stage 1: all elementary products
  logic signed [rvq_pkg::PUV_W-1:0]  puv [3][3];
  logic signed [rvq_pkg::PSQ_W-1:0]  psq [3];
  logic signed [rvq_pkg::PSQ_W-1:0]  pww;
  logic signed [rvq_pkg::VEC_W-1:0]  v1 [3];
  logic signed [rvq_pkg::QUAT_W-1:0] u1 [3];
  logic signed [rvq_pkg::QUAT_W-1:0] w1;

  // stage 2: u.v, w^2 - u.u, u x v
  logic signed [rvq_pkg::UV_W-1:0]   uv;
  logic signed [rvq_pkg::S2_W-1:0]   s2;
  logic signed [rvq_pkg::CR_W-1:0]   cr [3];
  logic signed [rvq_pkg::VEC_W-1:0]  v2 [3];
  logic signed [rvq_pkg::QUAT_W-1:0] u2 [3];
  logic signed [rvq_pkg::QUAT_W-1:0] w2;

  // stage 3: scaled terms
  logic signed [rvq_pkg::T1_W-1:0]   t1 [3];
  logic signed [rvq_pkg::T2_W-1:0]   t2 [3];
  logic signed [rvq_pkg::T3_W-1:0]   t3 [3];

  // stage 4: rounded sum
  logic signed [rvq_pkg::ACC_W-1:0]  acc [3];
  logic signed [rvq_pkg::RND_W-1:0]  rnd [3];
  logic [2:0]                        clip;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      out_valid <= 1'b0;
    end else if (ctrl.ce) begin
      valid     <= {valid[2:0], ctrl.valid};
      out_valid <= valid[3];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ce) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          puv[i][j] <= quat_u[i] * vec[j];
        end
        psq[i] <= quat_u[i] * quat_u[i];
        v1[i]  <= vec[i];
        u1[i]  <= quat_u[i];
      end
      pww <= quat_w * quat_w;
      w1  <= quat_w;

      uv <= rvq_pkg::UV_W'(puv[0][0]) + rvq_pkg::UV_W'(puv[1][1])
          + rvq_pkg::UV_W'(puv[2][2]);
      s2 <= rvq_pkg::S2_W'(pww) - rvq_pkg::S2_W'(psq[0])
          - rvq_pkg::S2_W'(psq[1]) - rvq_pkg::S2_W'(psq[2]);
      cr[0] <= rvq_pkg::CR_W'(puv[1][2]) - rvq_pkg::CR_W'(puv[2][1]);
      cr[1] <= rvq_pkg::CR_W'(puv[2][0]) - rvq_pkg::CR_W'(puv[0][2]);
      cr[2] <= rvq_pkg::CR_W'(puv[0][1]) - rvq_pkg::CR_W'(puv[1][0]);
      v2 <= v1;
      u2 <= u1;
      w2 <= w1;

      for (int i = 0; i < 3; i++) begin
        t1[i] <= uv * u2[i];
        t2[i] <= s2 * v2[i];
        t3[i] <= w2 * cr[i];
      end

      // all terms at 44 fraction bits, plus half an output lsb
      for (int i = 0; i < 3; i++) begin
        acc[i] <= (rvq_pkg::ACC_W'(t1[i]) <<< 1) + rvq_pkg::ACC_W'(t2[i])
                + (rvq_pkg::ACC_W'(t3[i]) <<< 1)
                + (rvq_pkg::ACC_W'(1) <<< (rvq_pkg::SHIFT_OUT - 1));
      end

      for (int i = 0; i < 3; i++) begin
        if (rnd[i] > rvq_pkg::RND_W'(rvq_pkg::OUT_MAX)) begin
          rot[i] <= rvq_pkg::VEC_W'(rvq_pkg::OUT_MAX);
        end else if (rnd[i] < rvq_pkg::RND_W'(rvq_pkg::OUT_MIN)) begin
          rot[i] <= rvq_pkg::VEC_W'(rvq_pkg::OUT_MIN);
        end else begin
          rot[i] <= rnd[i][rvq_pkg::VEC_W-1:0];
        end
      end
      saturated <= |clip;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i]  = acc[i][rvq_pkg::ACC_W-1:rvq_pkg::SHIFT_OUT];
      clip[i] = (rnd[i] > rvq_pkg::RND_W'(rvq_pkg::OUT_MAX))
             || (rnd[i] < rvq_pkg::RND_W'(rvq_pkg::OUT_MIN));
    end
  end

endmodule

@@ design/rvq_checker.sv @@
`include "rotate_vector_by_quaternion_defines.svh"

module rvq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic        m_tuser
);

  logic at_bound_x;
  logic at_bound_y;
  logic at_bound_z;

  assign at_bound_x = (m_tdata[23:0] == 24'h7fffff) || (m_tdata[23:0] == 24'h800000);
  assign at_bound_y = (m_tdata[47:24] == 24'h7fffff) || (m_tdata[47:24] == 24'h800000);
  assign at_bound_z = (m_tdata[71:48] == 24'h7fffff) || (m_tdata[71:48] == 24'h800000);

  `RVQ_ASSERT(a_hold_valid, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped")
  `RVQ_ASSERT(a_hold_data, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "stalled output changed")
  `RVQ_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "output valid after reset")
  `RVQ_ASSERT(a_ready_when_empty, clk, rst, !m_tvalid |-> s_tready, "not ready with empty output")
  `RVQ_ASSERT(a_sat_bound, clk, rst, m_tvalid && m_tuser |-> at_bound_x || at_bound_y || at_bound_z, "saturation flag without clamped value")

endmodule

bind rotate_vector_by_quaternion rvq_checker u_rvq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ bench/rotate_vector_by_quaternion_test.sv @@
`timescale 1ns / 100ps

module rotate_vector_by_quaternion_test;

  typedef struct {
    logic signed [rvq_pkg::VEC_W-1:0]  vx, vy, vz;
    logic signed [rvq_pkg::QUAT_W-1:0] qw, qx, qy, qz;
  } rot_in_t;

  typedef struct {
    logic signed [rvq_pkg::VEC_W-1:0] rx, ry, rz;
    logic                             sat;
  } rot_out_t;

  typedef struct {
    rot_in_t  stim;
    bit       typed;
    rot_out_t want;
  } table_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [135:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;
  logic         m_tuser;

  rot_out_t   rotations_due[$];
  table_row_t directed[$];
  int         mismatches = 0;
  int         stall_left = 0;
  bit         calm = 1'b0;

  rotate_vector_by_quaternion uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic rot_out_t rotated(rot_in_t a);
    longint v[3], u[3], cr[3];
    longint w, uv, uu, s2, acc, r;
    logic signed [rvq_pkg::VEC_W-1:0] c[3];
    rot_out_t res;
    v[0] = a.vx; v[1] = a.vy; v[2] = a.vz;
    u[0] = a.qx; u[1] = a.qy; u[2] = a.qz;
    w = a.qw;
    uv = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    uu = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
    s2 = w * w - uu;
    cr[0] = u[1] * v[2] - u[2] * v[1];
    cr[1] = u[2] * v[0] - u[0] * v[2];
    cr[2] = u[0] * v[1] - u[1] * v[0];
    res.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      // all three terms at 44 fraction bits; round half up to 16
      acc = 2 * uv * u[i] + s2 * v[i] + 2 * w * cr[i];
      r = (acc + (longint'(1) <<< (rvq_pkg::SHIFT_OUT - 1))) >>> rvq_pkg::SHIFT_OUT;
      if (r > rvq_pkg::OUT_MAX) begin
        r = rvq_pkg::OUT_MAX;
        res.sat = 1'b1;
      end else if (r < rvq_pkg::OUT_MIN) begin
        r = rvq_pkg::OUT_MIN;
        res.sat = 1'b1;
      end
      c[i] = r[rvq_pkg::VEC_W-1:0];
    end
    res.rx = c[0];
    res.ry = c[1];
    res.rz = c[2];
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [rvq_pkg::VEC_W-1:0] vec_edge();
    case ($urandom_range(0, 4))
      0: return rvq_pkg::VEC_W'(0);
      1: return rvq_pkg::VEC_W'(1);
      2: return rvq_pkg::VEC_W'(-1);
      3: return rvq_pkg::VEC_W'(rvq_pkg::OUT_MAX);
      default: return rvq_pkg::VEC_W'(rvq_pkg::OUT_MIN);
    endcase
  endfunction

  function automatic logic signed [rvq_pkg::QUAT_W-1:0] quat_edge();
    case ($urandom_range(0, 6))
      0: return rvq_pkg::QUAT_W'(0);
      1: return rvq_pkg::QUAT_W'(1);
      2: return rvq_pkg::QUAT_W'(-1);
      3: return rvq_pkg::QUAT_W'(16384);
      4: return rvq_pkg::QUAT_W'(-16384);
      5: return rvq_pkg::QUAT_W'(32767);
      default: return rvq_pkg::QUAT_W'(-32768);
    endcase
  endfunction

  function automatic rot_in_t random_item();
    rot_in_t a;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 4) begin
      a.vx = rvq_pkg::VEC_W'($urandom);
      a.vy = rvq_pkg::VEC_W'($urandom);
      a.vz = rvq_pkg::VEC_W'($urandom);
      a.qw = rvq_pkg::QUAT_W'($urandom);
      a.qx = rvq_pkg::QUAT_W'($urandom);
      a.qy = rvq_pkg::QUAT_W'($urandom);
      a.qz = rvq_pkg::QUAT_W'($urandom);
    end else if (mode < 8) begin
      // moderate vector, quaternion parts within +-1: stays clear of clamping
      a.vx = rvq_pkg::VEC_W'($urandom_range(0, 2097152) - 1048576);
      a.vy = rvq_pkg::VEC_W'($urandom_range(0, 2097152) - 1048576);
      a.vz = rvq_pkg::VEC_W'($urandom_range(0, 2097152) - 1048576);
      a.qw = rvq_pkg::QUAT_W'($urandom_range(0, 32768) - 16384);
      a.qx = rvq_pkg::QUAT_W'($urandom_range(0, 32768) - 16384);
      a.qy = rvq_pkg::QUAT_W'($urandom_range(0, 32768) - 16384);
      a.qz = rvq_pkg::QUAT_W'($urandom_range(0, 32768) - 16384);
    end else begin
      a.vx = vec_edge(); a.vy = vec_edge(); a.vz = vec_edge();
      a.qw = quat_edge(); a.qx = quat_edge(); a.qy = quat_edge(); a.qz = quat_edge();
    end
    return a;
  endfunction

  task automatic add_row(int vx, int vy, int vz, int qw, int qx, int qy, int qz,
                         bit typed, int ex, int ey, int ez, bit esat);
    table_row_t row;
    row.stim.vx = rvq_pkg::VEC_W'(vx);
    row.stim.vy = rvq_pkg::VEC_W'(vy);
    row.stim.vz = rvq_pkg::VEC_W'(vz);
    row.stim.qw = rvq_pkg::QUAT_W'(qw);
    row.stim.qx = rvq_pkg::QUAT_W'(qx);
    row.stim.qy = rvq_pkg::QUAT_W'(qy);
    row.stim.qz = rvq_pkg::QUAT_W'(qz);
    row.typed = typed;
    row.want.rx = rvq_pkg::VEC_W'(ex);
    row.want.ry = rvq_pkg::VEC_W'(ey);
    row.want.rz = rvq_pkg::VEC_W'(ez);
    row.want.sat = esat;
    directed.push_back(row);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send(rot_in_t a, bit typed, rot_out_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {$urandom, $urandom, $urandom, $urandom, 8'($urandom)};
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {a.qz, a.qy, a.qx, a.qw, a.vz, a.vy, a.vx};
    do @(posedge clk); while (!s_tready);
    rotations_due.push_back(typed ? want : rotated(a));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (rotations_due.size() != 0) @(posedge clk);
  endtask

  task automatic check_result();
    rot_out_t want;
    if (rotations_due.size() == 0) begin
      report_mismatch("transfer with no result due", $signed(m_tdata[23:0]), 0);
      return;
    end
    want = rotations_due.pop_front();
    if ($signed(m_tdata[23:0]) !== want.rx)
      report_mismatch("rot_x", $signed(m_tdata[23:0]), want.rx);
    if ($signed(m_tdata[47:24]) !== want.ry)
      report_mismatch("rot_y", $signed(m_tdata[47:24]), want.ry);
    if ($signed(m_tdata[71:48]) !== want.rz)
      report_mismatch("rot_z", $signed(m_tdata[71:48]), want.rz);
    if (m_tuser !== want.sat)
      report_mismatch("saturated", m_tuser, want.sat);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    rot_out_t unused_want;
    // zero in, zero out
    add_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    // identity quaternion, both signs of w
    add_row(8388607, -8388608, 65536, 16384, 0, 0, 0, 1, 8388607, -8388608, 65536, 0);
    add_row(-8388608, 8388607, -1, -16384, 0, 0, 0, 1, -8388608, 8388607, -1, 0);
    // zero quaternion kills the vector
    add_row(8388607, 8388607, 8388607, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    // |q|^2 = 4 scales by four and clamps both ways
    add_row(8388607, -8388608, 1, -32768, 0, 0, 0, 1, 8388607, -8388608, 4, 1);
    // half turns about z, x, y
    add_row(65536, -131072, 196608, 0, 0, 0, 16384, 1, -65536, 131072, 196608, 0);
    add_row(65536, -131072, 196608, 0, 16384, 0, 0, 1, 65536, 131072, -196608, 0);
    add_row(65536, -131072, 196608, 0, 0, 16384, 0, 1, -65536, -131072, -196608, 0);
    // negating the most negative component clamps
    add_row(-8388608, 8388607, 0, 0, 0, 0, 16384, 1, 8388607, -8388607, 0, 1);
    // exact halves round up
    add_row(2, -2, 6, 8192, 0, 0, 0, 1, 1, 0, 2, 0);
    add_row(-6, 10, -10, 8192, 0, 0, 0, 1, -1, 3, -2, 0);
    // extremes and bit patterns
    add_row(-8388608, -8388608, -8388608, -32768, -32768, -32768, -32768, 0, 0, 0, 0, 0);
    add_row(8388607, 8388607, 8388607, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 0);
    add_row(5592405, -5592406, 5592405, 21845, -21846, 21845, -21846, 0, 0, 0, 0, 0);
    add_row(-5592406, 5592405, -5592406, -21846, 21845, -21846, 21845, 0, 0, 0, 0, 0);
    add_row(1, 1, 1, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 0);
    add_row(-1, -1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 0);
    // quarter turn about z (non-unit quaternion), then two more rotations
    add_row(65536, 0, 0, 11585, 0, 0, 11585, 0, 0, 0, 0, 0);
    add_row(65536, -65536, 32768, 16384, 16384, 16384, 16384, 0, 0, 0, 0, 0);
    add_row(1234567, -7654321, 42, -20000, 3, -9000, 30000, 0, 0, 0, 0, 0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[k]) send(directed[k].stim, directed[k].typed, directed[k].want);
    drain();
    for (int n = 0; n < 1200; n++) begin
      calm = (n % 400) >= 300;
      if (n == 700) drain();
      send(random_item(), 1'b0, unused_want);
    end
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/rvq_pkg.sv
design/rvq_core.sv
design/rotate_vector_by_quaternion.sv
design/rvq_checker.sv
bench/rotate_vector_by_quaternion_test.sv
